FILE: rtl/rhdt_pkg.sv
// Shared types and constants for the resource hazard dependency tracker.
// No dependencies; imported by resource_hazard_dependency_tracker_unit and its testbench.
package rhdt_pkg;

  localparam int unsigned TaskW = 4;
  localparam int unsigned ResW  = 4;
  localparam int unsigned RowW  = 16;
  localparam int unsigned OpW   = 2;

  typedef enum logic [OpW-1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [TaskW-1:0] task_req;
    logic [ResW-1:0]  resource;
    logic             shared_read;
  } in_word_t;

  typedef struct packed {
    logic [TaskW-1:0] task_echo;
    logic [RowW-1:0]  depends_on;
    logic [RowW-1:0]  notifies;
  } out_word_t;

endpackage

FILE: rtl/resource_hazard_dependency_tracker_unit.sv
// Resource hazard dependency tracker: group masks per resource, dependency
// and notify rows per task. Depends on rhdt_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) carries one word per
//   access: record an access, read back a task's rows, or clear all tables.
//   Output channel (out_valid_o / out_stall_i / out_word_o) returns exactly one
//   word per input word, in order: the task and its (updated) dependency and
//   notify rows. Rows wider than 16 tasks are cut to the low 16 bits.
//   An accepted word goes to the input register, then through the table update
//   into the result register. Throughput: one word per cycle while the receiver
//   does not stall. The single pass between the input register and the result
//   register updates the tables and builds the result from their new values, so
//   each word sees the tables exactly as the previous word left them.
//   Reset clears both valids and every table (all groups and rows empty).
//   When the receiver stalls, the result word holds; the input register keeps
//   its word and in_stall_o rises until the result register frees up.
//   All tables are flip-flops; a clear operation empties all of them together.
module resource_hazard_dependency_tracker_unit
  import rhdt_pkg::*;
#(
  parameter int unsigned TASK_COUNT     = 16,
  parameter int unsigned RESOURCE_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned TIdxW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int unsigned RIdxW = (RESOURCE_COUNT > 1) ? $clog2(RESOURCE_COUNT) : 1;
  localparam int unsigned TWideW = (TIdxW > TaskW) ? TIdxW : TaskW;
  localparam int unsigned RWideW = (RIdxW > ResW) ? RIdxW : ResW;
  localparam int unsigned MaskWideW = (TASK_COUNT > RowW) ? TASK_COUNT : RowW;

  typedef logic [TASK_COUNT-1:0] mask_t;

  // Input register
  logic     in_valid_q;
  in_word_t in_word_q;

  // Result register
  logic      out_valid_q;
  out_word_t out_word_q;

  // Tables
  mask_t prev_grp_q [RESOURCE_COUNT];
  mask_t open_grp_q [RESOURCE_COUNT];
  mask_t dep_row_q  [TASK_COUNT];
  mask_t ntf_row_q  [TASK_COUNT];
  mask_t prev_grp_d [RESOURCE_COUNT];
  mask_t open_grp_d [RESOURCE_COUNT];
  mask_t dep_row_d  [TASK_COUNT];
  mask_t ntf_row_d  [TASK_COUNT];

  logic             out_free;
  logic             proc_fire;
  logic             in_accept;
  logic [TWideW-1:0] task_wide;
  logic [RWideW-1:0] res_wide;
  logic [TIdxW-1:0] task_idx;
  logic [RIdxW-1:0] res_idx;
  logic             task_ok;
  logic             res_ok;
  logic             is_write;
  mask_t            task_bit;
  mask_t            deps;
  logic [MaskWideW-1:0] dep_wide;
  logic [MaskWideW-1:0] ntf_wide;
  out_word_t        result_d;

  // Handshake: result register frees when empty or being taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc_fire  = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
  end

  // Index decode with range checks
  assign task_wide = TWideW'(in_word_q.task_req);
  assign res_wide  = RWideW'(in_word_q.resource);
  assign task_idx  = task_wide[TIdxW-1:0];
  assign res_idx   = res_wide[RIdxW-1:0];
  assign task_ok   = 32'(in_word_q.task_req) < 32'(TASK_COUNT);
  assign res_ok    = 32'(in_word_q.resource) < 32'(RESOURCE_COUNT);
  assign is_write  = !in_word_q.shared_read;
  assign task_bit  = mask_t'(1) << task_idx;

  // Table update for the word in the input register
  always_comb begin
    prev_grp_d = prev_grp_q;
    open_grp_d = open_grp_q;
    dep_row_d  = dep_row_q;
    ntf_row_d  = ntf_row_q;
    deps       = '0;
    if (proc_fire) begin
      case (in_word_q.operation)
        OP_CLEAR: begin
          for (int r = 0; r < RESOURCE_COUNT; r++) begin
            prev_grp_d[r] = '0;
            open_grp_d[r] = '0;
          end
          for (int t = 0; t < TASK_COUNT; t++) begin
            dep_row_d[t] = '0;
            ntf_row_d[t] = '0;
          end
        end
        OP_RECORD: begin
          if (task_ok && res_ok) begin
            if (!is_write) begin
              // reader waits on the last writer group and joins the readers
              deps = prev_grp_q[res_idx];
              open_grp_d[res_idx] = open_grp_q[res_idx] | task_bit;
            end else begin
              // writer waits on open readers, else on the previous group
              deps = (open_grp_q[res_idx] != '0) ? open_grp_q[res_idx]
                                                 : prev_grp_q[res_idx];
              prev_grp_d[res_idx] = task_bit;
              open_grp_d[res_idx] = '0;
            end
            dep_row_d[task_idx] = dep_row_q[task_idx] | deps;
            for (int t = 0; t < TASK_COUNT; t++) begin
              if (deps[t]) begin
                ntf_row_d[t] = ntf_row_q[t] | task_bit;
              end
            end
          end
        end
        default: begin
          // read back, tables unchanged
        end
      endcase
    end
  end

  // Result from the updated tables
  always_comb begin
    dep_wide = task_ok ? MaskWideW'(dep_row_d[task_idx]) : '0;
    ntf_wide = task_ok ? MaskWideW'(ntf_row_d[task_idx]) : '0;
    result_d.task_echo  = in_word_q.task_req;
    result_d.depends_on = dep_wide[RowW-1:0];
    result_d.notifies   = ntf_wide[RowW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RESOURCE_COUNT; r++) begin
        prev_grp_q[r] <= '0;
        open_grp_q[r] <= '0;
      end
      for (int t = 0; t < TASK_COUNT; t++) begin
        dep_row_q[t] <= '0;
        ntf_row_q[t] <= '0;
      end
    end else begin
      prev_grp_q <= prev_grp_d;
      open_grp_q <= open_grp_d;
      dep_row_q  <= dep_row_d;
      ntf_row_q  <= ntf_row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= proc_fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_word_q <= result_d;
    end
  end

`ifndef SYNTH
  // A new result only appears after a word was processed.
  a_out_from_proc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc_fire))
    else $error("result valid without a processed word");

  // A clear reports empty rows.
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && (in_word_q.operation == OP_CLEAR)
    |=> (out_word_q.depends_on == '0) && (out_word_q.notifies == '0))
    else $error("clear returned nonempty rows");

  // After a write the writer alone forms the previous group.
  a_write_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && (in_word_q.operation == OP_RECORD) && task_ok && res_ok && is_write
    |=> $onehot(prev_grp_q[$past(res_idx)]) && (open_grp_q[$past(res_idx)] == '0))
    else $error("write left group masks inconsistent");

  // A task outside the table reports empty rows.
  a_bad_task_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (32'(out_word_q.task_echo) >= 32'(TASK_COUNT))
    |-> (out_word_q.depends_on == '0) && (out_word_q.notifies == '0))
    else $error("out-of-range task reported rows");
`endif

endmodule

FILE: sim/tb_resource_hazard_dependency_tracker_unit.sv
// Testbench for resource_hazard_dependency_tracker_unit: directed table, then random
// access streams, checked against a local model of the group masks and task rows
// (typed table rows against their listed rows). Depends on rhdt_pkg and the tracker RTL.
module tb_resource_hazard_dependency_tracker_unit;
  import rhdt_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;  // no enum member; reads rows
  localparam logic RdShared = 1'b1;
  localparam logic WrExcl   = 1'b0;
  localparam int NumPlan    = 22;
  localparam int NumRandom  = 800;
  localparam int NumTask    = 2**TaskW;
  localparam int NumRes     = 2**ResW;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [TaskW-1:0] tsk;
    logic [ResW-1:0]  res;
    logic             shr;
    bit               typed;  // dep/ntf below are the expected rows
    logic [RowW-1:0]  dep;
    logic [RowW-1:0]  ntf;
  } plan_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  // local copy of the tracker tables
  logic [RowW-1:0] grp_prev [NumRes];
  logic [RowW-1:0] grp_open [NumRes];
  logic [RowW-1:0] dep_rows [NumTask];
  logic [RowW-1:0] ntf_rows [NumTask];

  out_word_t pending_rows [$];
  int        words_sent;
  int        mismatches;
  plan_row_t plan [NumPlan];

  resource_hazard_dependency_tracker_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_tables();
    for (int r = 0; r < NumRes; r++) begin
      grp_prev[r] = '0;
      grp_open[r] = '0;
    end
    for (int t = 0; t < NumTask; t++) begin
      dep_rows[t] = '0;
      ntf_rows[t] = '0;
    end
  endfunction

  // Applies one word to the local tables and returns the rows it reports.
  function automatic out_word_t predict_rows(input in_word_t w);
    logic [RowW-1:0] deps;
    logic [RowW-1:0] me;
    out_word_t       r;
    me = RowW'(1) << w.task_req;
    case (w.operation)
      OP_RECORD: begin
        if (w.shared_read) begin
          deps = grp_prev[w.resource];
          grp_open[w.resource] |= me;
        end else begin
          // writer waits on readers since the last write, else on that writer
          deps = (grp_open[w.resource] != '0) ? grp_open[w.resource]
                                              : grp_prev[w.resource];
          grp_prev[w.resource] = me;
          grp_open[w.resource] = '0;
        end
        dep_rows[w.task_req] |= deps;
        for (int k = 0; k < NumTask; k++) begin
          if (deps[k]) ntf_rows[k] |= me;
        end
      end
      OP_CLEAR: clear_tables();
      default: ;
    endcase
    r.task_echo  = w.task_req;
    r.depends_on = dep_rows[w.task_req];
    r.notifies   = ntf_rows[w.task_req];
    return r;
  endfunction

  task automatic send_word(input in_word_t w, input bit typed,
                           input logic [RowW-1:0] dep, input logic [RowW-1:0] ntf);
    out_word_t want;
    @(negedge clk_i);
    while (!(words_sent >= 300 && words_sent < 500) && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    want = predict_rows(w);
    if (typed) begin
      want.depends_on = dep;
      want.notifies   = ntf;
    end
    pending_rows = {pending_rows, want};
    words_sent++;
  endtask

  // receiver: random stalls, one long hold-off, one calm stretch
  initial begin : rx_stall
    int  hold;
    bit  held_once;
    hold      = 0;
    held_once = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_once && words_sent >= 250) begin
        held_once = 1'b1;
        hold      = 60;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (words_sent >= 550 && words_sent < 700) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 15);
      end
    end
  end

  always @(posedge clk_i) begin : check_rows
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected result word: task_echo %0d", out_word_o.task_echo);
        mismatches++;
      end else begin
        want = pending_rows.pop_front();
        if (out_word_o.task_echo !== want.task_echo) begin
          $error("task_echo: expected %0d, got %0d", want.task_echo, out_word_o.task_echo);
          mismatches++;
        end
        if (out_word_o.depends_on !== want.depends_on) begin
          $error("depends_on: expected %h, got %h", want.depends_on,
                 out_word_o.depends_on);
          mismatches++;
        end
        if (out_word_o.notifies !== want.notifies) begin
          $error("notifies: expected %h, got %h", want.notifies, out_word_o.notifies);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #500000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    in_word_t w;
    int       cur_task;
    int       pick;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    words_sent = 0;
    mismatches = 0;
    cur_task   = 0;
    clear_tables();
    plan = '{
      // reset state, both ends of the task range, spare op code
      '{OP_READ,   4'd0,  4'd0,  WrExcl,   1'b1, 16'h0000, 16'h0000},
      '{OP_READ,   4'd15, 4'd15, RdShared, 1'b1, 16'h0000, 16'h0000},
      '{OpUnused,  4'd7,  4'd3,  RdShared, 1'b1, 16'h0000, 16'h0000},
      // first writer on an untouched resource waits on nobody
      '{OP_RECORD, 4'd0,  4'd0,  WrExcl,   1'b1, 16'h0000, 16'h0000},
      '{OP_RECORD, 4'd1,  4'd0,  RdShared, 1'b0, 16'h0000, 16'h0000},
      '{OP_RECORD, 4'd2,  4'd0,  RdShared, 1'b0, 16'h0000, 16'h0000},
      '{OP_RECORD, 4'd3,  4'd0,  WrExcl,   1'b0, 16'h0000, 16'h0000},
      '{OP_RECORD, 4'd4,  4'd0,  RdShared, 1'b0, 16'h0000, 16'h0000},
      '{OP_READ,   4'd0,  4'd9,  RdShared, 1'b0, 16'h0000, 16'h0000},
      '{OpUnused,  4'd3,  4'd0,  WrExcl,   1'b0, 16'h0000, 16'h0000},
      // a task writing twice ends up waiting on itself
      '{OP_RECORD, 4'd15, 4'd15, WrExcl,   1'b1, 16'h0000, 16'h0000},
      '{OP_RECORD, 4'd15, 4'd15, WrExcl,   1'b1, 16'h8000, 16'h8000},
      '{OP_RECORD, 4'd14, 4'd15, RdShared, 1'b0, 16'h0000, 16'h0000},
      '{OP_RECORD, 4'd14, 4'd15, WrExcl,   1'b0, 16'h0000, 16'h0000},
      '{OP_RECORD, 4'd13, 4'd15, RdShared, 1'b0, 16'h0000, 16'h0000},
      // clear wipes every table
      '{OP_CLEAR,  4'd5,  4'd10, RdShared, 1'b1, 16'h0000, 16'h0000},
      '{OP_READ,   4'd14, 4'd0,  WrExcl,   1'b1, 16'h0000, 16'h0000},
      '{OP_RECORD, 4'd9,  4'd7,  RdShared, 1'b1, 16'h0000, 16'h0000},
      '{OP_RECORD, 4'd10, 4'd7,  RdShared, 1'b1, 16'h0000, 16'h0000},
      '{OP_RECORD, 4'd11, 4'd7,  WrExcl,   1'b0, 16'h0000, 16'h0000},
      '{OP_READ,   4'd9,  4'd0,  WrExcl,   1'b0, 16'h0000, 16'h0000},
      '{OP_CLEAR,  4'd15, 4'd15, WrExcl,   1'b1, 16'h0000, 16'h0000}
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumPlan; i++) begin
      w.operation   = plan[i].op;
      w.task_req    = plan[i].tsk;
      w.resource    = plan[i].res;
      w.shared_read = plan[i].shr;
      send_word(w, plan[i].typed, plan[i].dep, plan[i].ntf);
    end

    // mostly accesses in rising task order over a few hot resources
    repeat (NumRandom) begin
      pick = $urandom_range(0, 99);
      if (pick < 2)       w.operation = OP_CLEAR;
      else if (pick < 12) w.operation = OP_READ;
      else if (pick < 16) w.operation = OpUnused;
      else                w.operation = OP_RECORD;
      if ($urandom_range(0, 4) == 0) cur_task = $urandom_range(0, NumTask - 1);
      else if ($urandom_range(0, 1) == 1) cur_task = (cur_task + 1) % NumTask;
      w.task_req    = cur_task[TaskW-1:0];
      w.resource    = ($urandom_range(0, 1) == 1) ? ResW'($urandom_range(0, 3))
                                                  : ResW'($urandom_range(0, NumRes - 1));
      w.shared_read = ($urandom_range(0, 2) != 0) ? RdShared : WrExcl;
      send_word(w, 1'b0, '0, '0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: resource_hazard_dependency_tracker_unit.f
rtl/rhdt_pkg.sv
rtl/resource_hazard_dependency_tracker_unit.sv
sim/tb_resource_hazard_dependency_tracker_unit.sv
